// File: hw/rtl/itp_reasm_pkg.sv
`timescale 1ns / 1ps

package itp_reasm_pkg;

    localparam int BUF_BYTES   = 256;
    localparam int ADDR_W      = $clog2(BUF_BYTES);
    localparam int FILL_W      = $clog2(BUF_BYTES + 1);
    localparam int CHUNK_BYTES = 8;
    localparam int SF_MAX      = 7;
    localparam int FF_BYTES    = 6;

    localparam logic [3:0] SEQ_MASK = 4'hF;

    localparam logic [1:0] KIND_CHUNK = 2'd0;
    localparam logic [1:0] KIND_FLOW  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    localparam logic [1:0] RSN_UNEXPECTED = 2'd0;
    localparam logic [1:0] RSN_OVERFLOW   = 2'd1;
    localparam logic [1:0] RSN_TIMEOUT    = 2'd2;

    localparam logic FS_CONTINUE = 1'b0;
    localparam logic FS_OVERFLOW = 1'b1;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [3:0] FT_SINGLE  = 4'h0;
    localparam logic [3:0] FT_FIRST   = 4'h1;
    localparam logic [3:0] FT_CONSEC  = 4'h2;
    localparam logic [3:0] FT_FLOW    = 4'h3;
    localparam logic [3:0] FT_UNKNOWN = 4'hF;

    localparam int TDATA_IN_W  = 72;
    localparam int TDATA_OUT_W = 72;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_WR,
        S_PUSH_FC,
        S_PUSH_AB,
        S_CHUNK,
        S_RD,
        S_PUSH_CH
    } t_state;

    typedef enum logic [1:0] {
        WM_SF,
        WM_FF,
        WM_CF
    } t_wmode;

endpackage

// File: hw/rtl/iso_tp_segment_reassembler_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Width      Fields (low bit up)
// s_axis   in   tdata 72   frame_length[3:0], byte0..byte7 [67:4]
//               tuser 1    operation
// m_axis   out  tdata 72   chunk_data[63:0], chunk_bytes[67:64], flow_status[68],
//                          abort_reason[70:69]
//               tuser 2    kind; tlast = last
// cfg      in   16         timeout_ticks, written when i_cfg_wr_en is high
//
// A tick is decoded and, when it times out, places an abort result. A frame is decoded, then
// places any flow control or abort result; a valid single, first or consecutive frame
// also stores its bytes and closes the write. A PDU drains through the single read port
// of the assembly RAM, one byte per cycle within a chunk, but a held result stalls the drain.
// Synchronous active-low reset clears control state; the RAM is not cleared.
// A held result stalls the sequencer only when it must place the next one.

module iso_tp_segment_reassembler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // frame_length[3:0], byte0[11:4] .. byte7[67:60], zero pad [71:68]
    input  logic [itp_reasm_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chunk_data[63:0], chunk_bytes[67:64], flow_status[68], abort_reason[70:69], pad[71]
    output logic [itp_reasm_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int AW = itp_reasm_pkg::ADDR_W;
    localparam int FW = itp_reasm_pkg::FILL_W;

    itp_reasm_pkg::t_state r_state, n_state;
    itp_reasm_pkg::t_wmode r_mode, n_mode;

    logic          r_ovalid, n_ovalid;
    logic          r_recv, n_recv;
    logic [FW-1:0] r_fill, n_fill;
    logic [3:0]    r_seq, n_seq;
    logic [FW-1:0] r_etotal, n_etotal;
    logic [15:0]   r_tcount, n_tcount;
    logic [15:0]   r_ticks, n_ticks;
    logic          r_pend, n_pend;
    logic [3:0]    r_iss, n_iss;
    logic [3:0]    r_cap, n_cap;
    logic [3:0]    r_cn, n_cn;
    logic [3:0]    r_wcnt, n_wcnt;

    logic          r_op, n_op;
    logic [3:0]    r_flen, n_flen;
    logic [63:0]   r_data, n_data;
    logic [FW-1:0] r_lim, n_lim;
    logic [1:0]    r_reason, n_reason;
    logic          r_fc_ovf, n_fc_ovf;
    logic [FW-1:0] r_emit_tot, n_emit_tot;
    logic [FW-1:0] r_roff, n_roff;
    logic [63:0]   r_chunk, n_chunk;
    logic [1:0]    r_okind, n_okind;
    logic [63:0]   r_odata, n_odata;
    logic [3:0]    r_obytes, n_obytes;
    logic          r_olast, n_olast;
    logic          r_ofs, n_ofs;
    logic [1:0]    r_oreason, n_oreason;
    logic [7:0]    r_rdata;

    logic [7:0]    mem [itp_reasm_pkg::BUF_BYTES];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    logic          out_free;
    logic [3:0]    d_type;
    logic [3:0]    d_sflen;
    logic [11:0]   d_len12;
    logic [3:0]    in_flen;
    logic [FW-1:0] rem;

    assign out_free = !r_ovalid || m_axis_tready;
    assign d_type   = (r_flen == 4'd0) ? itp_reasm_pkg::FT_UNKNOWN : r_data[7:4];
    assign d_sflen  = r_data[3:0] & itp_reasm_pkg::SEQ_MASK;
    assign d_len12  = {r_data[3:0], r_data[15:8]};
    assign in_flen  = s_axis_tdata[3:0];
    assign rem      = r_emit_tot - r_roff;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_recv     = r_recv;
        n_fill     = r_fill;
        n_seq      = r_seq;
        n_etotal   = r_etotal;
        n_tcount   = r_tcount;
        n_ticks    = i_cfg_wr_en ? i_cfg_wr_data : r_ticks;
        n_pend     = 1'b0;
        n_iss      = r_iss;
        n_cap      = r_cap;
        n_cn       = r_cn;
        n_wcnt     = r_wcnt;
        n_op       = r_op;
        n_flen     = r_flen;
        n_data     = r_data;
        n_lim      = r_lim;
        n_reason   = r_reason;
        n_fc_ovf   = r_fc_ovf;
        n_emit_tot = r_emit_tot;
        n_roff     = r_roff;
        n_chunk    = r_chunk;
        n_okind    = r_okind;
        n_odata    = r_odata;
        n_obytes   = r_obytes;
        n_olast    = r_olast;
        n_ofs      = r_ofs;
        n_oreason  = r_oreason;
        mem_we     = 1'b0;
        mem_wa     = r_fill[AW-1:0];
        mem_re     = 1'b0;
        mem_ra     = r_roff[AW-1:0];

        unique case (r_state)
            itp_reasm_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = s_axis_tuser;
                    n_flen  = (in_flen > 4'(itp_reasm_pkg::CHUNK_BYTES))
                              ? 4'(itp_reasm_pkg::CHUNK_BYTES) : in_flen;
                    n_data  = s_axis_tdata[67:4];
                    n_state = itp_reasm_pkg::S_DEC;
                end
            end

            itp_reasm_pkg::S_DEC: begin
                n_state = itp_reasm_pkg::S_IDLE;
                if (r_op == itp_reasm_pkg::OP_TICK) begin
                    if (r_recv) begin
                        if (r_tcount <= 16'd1) begin
                            n_recv   = 1'b0;
                            n_fill   = '0;
                            n_tcount = '0;
                            n_reason = itp_reasm_pkg::RSN_TIMEOUT;
                            n_state  = itp_reasm_pkg::S_PUSH_AB;
                        end else begin
                            n_tcount = r_tcount - 16'd1;
                        end
                    end
                end else begin
                    unique case (d_type)
                        itp_reasm_pkg::FT_SINGLE: begin
                            n_recv   = 1'b0;
                            n_fill   = '0;
                            if (r_recv) begin
                                n_tcount = '0;
                            end
                            if (d_sflen == 4'd0 || d_sflen > 4'(itp_reasm_pkg::SF_MAX)
                                || d_sflen > r_flen - 4'd1) begin
                                n_reason = itp_reasm_pkg::RSN_UNEXPECTED;
                                n_tcount = '0;
                                n_state  = itp_reasm_pkg::S_PUSH_AB;
                            end else begin
                                n_mode  = itp_reasm_pkg::WM_SF;
                                n_wcnt  = d_sflen;
                                n_lim   = FW'(d_sflen);
                                n_data  = r_data >> 8;
                                n_state = itp_reasm_pkg::S_WR;
                            end
                        end
                        itp_reasm_pkg::FT_FIRST: begin
                            if (r_flen < 4'(itp_reasm_pkg::CHUNK_BYTES)
                                || d_len12 <= 12'(itp_reasm_pkg::SF_MAX)) begin
                                n_recv   = 1'b0;
                                n_fill   = '0;
                                n_tcount = '0;
                                n_reason = itp_reasm_pkg::RSN_UNEXPECTED;
                                n_state  = itp_reasm_pkg::S_PUSH_AB;
                            end else if (d_len12 > 12'(itp_reasm_pkg::BUF_BYTES)) begin
                                n_recv   = 1'b0;
                                n_fill   = '0;
                                n_tcount = '0;
                                n_reason = itp_reasm_pkg::RSN_OVERFLOW;
                                n_fc_ovf = itp_reasm_pkg::FS_OVERFLOW;
                                n_state  = itp_reasm_pkg::S_PUSH_FC;
                            end else begin
                                n_etotal = d_len12[FW-1:0];
                                n_seq    = 4'd1;
                                n_fill   = '0;
                                n_recv   = 1'b1;
                                n_tcount = r_ticks;
                                n_fc_ovf = itp_reasm_pkg::FS_CONTINUE;
                                n_mode   = itp_reasm_pkg::WM_FF;
                                n_wcnt   = 4'(itp_reasm_pkg::FF_BYTES);
                                n_lim    = FW'(itp_reasm_pkg::BUF_BYTES);
                                n_data   = r_data >> 16;
                                n_state  = itp_reasm_pkg::S_WR;
                            end
                        end
                        itp_reasm_pkg::FT_CONSEC: begin
                            if (r_recv) begin
                                if (d_sflen != r_seq) begin
                                    n_recv   = 1'b0;
                                    n_fill   = '0;
                                    n_tcount = '0;
                                    n_reason = itp_reasm_pkg::RSN_UNEXPECTED;
                                    n_state  = itp_reasm_pkg::S_PUSH_AB;
                                end else begin
                                    n_seq    = (r_seq + 4'd1) & itp_reasm_pkg::SEQ_MASK;
                                    n_tcount = r_ticks;
                                    n_mode   = itp_reasm_pkg::WM_CF;
                                    n_wcnt   = r_flen - 4'd1;
                                    n_lim    = r_etotal;
                                    n_data   = r_data >> 8;
                                    n_state  = itp_reasm_pkg::S_WR;
                                end
                            end
                        end
                        itp_reasm_pkg::FT_FLOW: begin
                            n_state = itp_reasm_pkg::S_IDLE;
                        end
                        default: begin
                            n_recv   = 1'b0;
                            n_fill   = '0;
                            n_tcount = '0;
                            n_reason = itp_reasm_pkg::RSN_UNEXPECTED;
                            n_state  = itp_reasm_pkg::S_PUSH_AB;
                        end
                    endcase
                end
            end

            itp_reasm_pkg::S_WR: begin
                if (r_wcnt != 4'd0 && r_fill < r_lim) begin
                    mem_we = 1'b1;
                    n_fill = r_fill + FW'(1);
                    n_wcnt = r_wcnt - 4'd1;
                    n_data = r_data >> 8;
                end else begin
                    unique case (r_mode)
                        itp_reasm_pkg::WM_SF: begin
                            n_emit_tot = r_lim;
                            n_fill     = '0;
                            n_roff     = '0;
                            n_state    = itp_reasm_pkg::S_CHUNK;
                        end
                        itp_reasm_pkg::WM_FF: begin
                            n_state = itp_reasm_pkg::S_PUSH_FC;
                        end
                        itp_reasm_pkg::WM_CF: begin
                            if (r_fill >= r_etotal) begin
                                n_recv     = 1'b0;
                                n_fill     = '0;
                                n_tcount   = '0;
                                n_emit_tot = r_etotal;
                                n_roff     = '0;
                                n_state    = itp_reasm_pkg::S_CHUNK;
                            end else begin
                                n_state = itp_reasm_pkg::S_IDLE;
                            end
                        end
                        default: begin
                            n_state = itp_reasm_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            itp_reasm_pkg::S_PUSH_FC: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = itp_reasm_pkg::KIND_FLOW;
                    n_odata   = '0;
                    n_obytes  = '0;
                    n_olast   = 1'b0;
                    n_ofs     = r_fc_ovf;
                    n_oreason = itp_reasm_pkg::RSN_UNEXPECTED;
                    n_state   = (r_fc_ovf == itp_reasm_pkg::FS_OVERFLOW)
                                ? itp_reasm_pkg::S_PUSH_AB : itp_reasm_pkg::S_IDLE;
                end
            end

            itp_reasm_pkg::S_PUSH_AB: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = itp_reasm_pkg::KIND_ABORT;
                    n_odata   = '0;
                    n_obytes  = '0;
                    n_olast   = 1'b0;
                    n_ofs     = itp_reasm_pkg::FS_CONTINUE;
                    n_oreason = r_reason;
                    n_state   = itp_reasm_pkg::S_IDLE;
                end
            end

            itp_reasm_pkg::S_CHUNK: begin
                n_cn    = (rem > FW'(itp_reasm_pkg::CHUNK_BYTES))
                          ? 4'(itp_reasm_pkg::CHUNK_BYTES) : rem[3:0];
                n_iss   = '0;
                n_cap   = '0;
                n_chunk = '0;
                n_state = itp_reasm_pkg::S_RD;
            end

            itp_reasm_pkg::S_RD: begin
                if (r_iss < r_cn) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_roff = r_roff + FW'(1);
                    n_iss  = r_iss + 4'd1;
                end
                if (r_pend) begin
                    n_chunk[{r_cap[2:0], 3'b000} +: 8] = r_rdata;
                    n_cap = r_cap + 4'd1;
                end
                if (r_cap == r_cn) begin
                    n_state = itp_reasm_pkg::S_PUSH_CH;
                end
            end

            itp_reasm_pkg::S_PUSH_CH: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = itp_reasm_pkg::KIND_CHUNK;
                    n_odata   = r_chunk;
                    n_obytes  = r_cn;
                    n_olast   = (r_roff >= r_emit_tot);
                    n_ofs     = itp_reasm_pkg::FS_CONTINUE;
                    n_oreason = itp_reasm_pkg::RSN_UNEXPECTED;
                    n_state   = (r_roff >= r_emit_tot)
                                ? itp_reasm_pkg::S_IDLE : itp_reasm_pkg::S_CHUNK;
                end
            end

            default: begin
                n_state = itp_reasm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= itp_reasm_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_recv   <= 1'b0;
            r_fill   <= '0;
            r_seq    <= '0;
            r_etotal <= '0;
            r_tcount <= '0;
            r_ticks  <= 16'd1000;
            r_pend   <= 1'b0;
            r_iss    <= '0;
            r_cap    <= '0;
            r_cn     <= '0;
            r_wcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_recv   <= n_recv;
            r_fill   <= n_fill;
            r_seq    <= n_seq;
            r_etotal <= n_etotal;
            r_tcount <= n_tcount;
            r_ticks  <= n_ticks;
            r_pend   <= n_pend;
            r_iss    <= n_iss;
            r_cap    <= n_cap;
            r_cn     <= n_cn;
            r_wcnt   <= n_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_op       <= n_op;
        r_flen     <= n_flen;
        r_data     <= n_data;
        r_lim      <= n_lim;
        r_reason   <= n_reason;
        r_fc_ovf   <= n_fc_ovf;
        r_emit_tot <= n_emit_tot;
        r_roff     <= n_roff;
        r_chunk    <= n_chunk;
        r_okind    <= n_okind;
        r_odata    <= n_odata;
        r_obytes   <= n_obytes;
        r_olast    <= n_olast;
        r_ofs      <= n_ofs;
        r_oreason  <= n_oreason;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= r_data[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    assign s_axis_tready = (r_state == itp_reasm_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_oreason, r_ofs, r_obytes, r_odata};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

endmodule

// File: hw/rtl/itp_reasm_chk.sv
`timescale 1ns / 1ps

module itp_reasm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [itp_reasm_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == itp_reasm_pkg::KIND_CHUNK
                           || m_axis_tuser == itp_reasm_pkg::KIND_FLOW
                           || m_axis_tuser == itp_reasm_pkg::KIND_ABORT))
        else $error("illegal result kind");

    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == itp_reasm_pkg::KIND_CHUNK)
        |-> (m_axis_tdata[67:64] != 4'd0 && m_axis_tdata[67:64] <= 4'd8))
        else $error("chunk byte count out of range");

    a_ctrl_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != itp_reasm_pkg::KIND_CHUNK)
        |-> (m_axis_tdata[67:0] == 68'd0 && !m_axis_tlast))
        else $error("control result carries chunk payload");

    a_ovf_then_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser == itp_reasm_pkg::KIND_FLOW
         && m_axis_tdata[68]) |=> (!m_axis_tvalid || m_axis_tuser == itp_reasm_pkg::KIND_ABORT))
        else $error("overflow flow control not followed by abort");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled transaction changed");

endmodule

bind iso_tp_segment_reassembler_top itp_reasm_chk u_itp_reasm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: dv/iso_tp_segment_reassembler_top_tb.sv
`timescale 1ns / 1ps

module iso_tp_segment_reassembler_top_tb;

    localparam int STUCK_LIMIT = 4000;

    typedef struct packed {
        logic            op;
        logic [3:0]      flen;
        logic [7:0][7:0] pay;
    } t_can_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        fin;
        logic        fs;
        logic [1:0]  reason;
    } t_reply;

    class t_reasm_scoreboard;
        t_reply      awaited_replies[$];
        int          mismatches = 0;
        logic [15:0] tmo_ticks = 16'd1000;
        logic        rx_active = 1'b0;
        logic [3:0]  next_sn = '0;
        int unsigned pdu_len = 0;
        int unsigned fill = 0;
        logic [15:0] tmo_left = '0;
        logic [7:0]  pdu_buf[itp_reasm_pkg::BUF_BYTES];

        function void set_timeout(logic [15:0] v);
            tmo_ticks = v;
        endfunction

        function void push_reply(logic [1:0] kind, logic [63:0] data, logic [3:0] nbytes,
                                 logic fin, logic fs, logic [1:0] reason);
            t_reply r;
            r.kind   = kind;
            r.data   = data;
            r.nbytes = nbytes;
            r.fin    = fin;
            r.fs     = fs;
            r.reason = reason;
            awaited_replies.insert(awaited_replies.size(), r);
        endfunction

        function void drop_transfer();
            rx_active = 1'b0;
            fill      = 0;
            tmo_left  = '0;
        endfunction

        function void push_abort(logic [1:0] reason);
            drop_transfer();
            push_reply(itp_reasm_pkg::KIND_ABORT, '0, '0, 1'b0,
                       itp_reasm_pkg::FS_CONTINUE, reason);
        endfunction

        function void deliver_pdu(int unsigned total);
            int unsigned off;
            int unsigned n;
            logic [63:0] word;
            off = 0;
            while (off < total) begin
                n = (total - off > itp_reasm_pkg::CHUNK_BYTES)
                    ? itp_reasm_pkg::CHUNK_BYTES : total - off;
                word = '0;
                for (int unsigned i = 0; i < n; i++) begin
                    word[8*i +: 8] = pdu_buf[off + i];
                end
                push_reply(itp_reasm_pkg::KIND_CHUNK, word, n[3:0], (off + n >= total),
                           itp_reasm_pkg::FS_CONTINUE, itp_reasm_pkg::RSN_UNEXPECTED);
                off += n;
            end
        endfunction

        function void reassemble(t_can_item it);
            int unsigned flen;
            int unsigned len;
            logic [3:0]  ftype;
            if (it.op == itp_reasm_pkg::OP_TICK) begin
                if (rx_active) begin
                    if (tmo_left <= 1) push_abort(itp_reasm_pkg::RSN_TIMEOUT);
                    else tmo_left--;
                end
                return;
            end
            flen  = (it.flen > 8) ? 8 : it.flen;
            ftype = (flen == 0) ? itp_reasm_pkg::FT_UNKNOWN : it.pay[0][7:4];
            case (ftype)
                itp_reasm_pkg::FT_SINGLE: begin
                    len = it.pay[0][3:0];
                    if (rx_active) drop_transfer();
                    if (len == 0 || len > itp_reasm_pkg::SF_MAX || len > flen - 1) begin
                        push_abort(itp_reasm_pkg::RSN_UNEXPECTED);
                    end else begin
                        for (int unsigned i = 0; i < len; i++) pdu_buf[i] = it.pay[i + 1];
                        deliver_pdu(len);
                    end
                end
                itp_reasm_pkg::FT_FIRST: begin
                    len = {it.pay[0][3:0], it.pay[1]};
                    if (flen < 8 || len <= itp_reasm_pkg::SF_MAX) begin
                        push_abort(itp_reasm_pkg::RSN_UNEXPECTED);
                    end else if (len > itp_reasm_pkg::BUF_BYTES) begin
                        push_reply(itp_reasm_pkg::KIND_FLOW, '0, '0, 1'b0,
                                   itp_reasm_pkg::FS_OVERFLOW,
                                   itp_reasm_pkg::RSN_UNEXPECTED);
                        push_abort(itp_reasm_pkg::RSN_OVERFLOW);
                    end else begin
                        pdu_len = len;
                        next_sn = 4'd1;
                        fill    = 0;
                        for (int unsigned i = 2; i < 8; i++) begin
                            pdu_buf[fill] = it.pay[i];
                            fill++;
                        end
                        rx_active = 1'b1;
                        tmo_left  = tmo_ticks;
                        push_reply(itp_reasm_pkg::KIND_FLOW, '0, '0, 1'b0,
                                   itp_reasm_pkg::FS_CONTINUE,
                                   itp_reasm_pkg::RSN_UNEXPECTED);
                    end
                end
                itp_reasm_pkg::FT_CONSEC: begin
                    if (rx_active) begin
                        if (it.pay[0][3:0] != next_sn) begin
                            push_abort(itp_reasm_pkg::RSN_UNEXPECTED);
                        end else begin
                            next_sn++;
                            tmo_left = tmo_ticks;
                            for (int unsigned i = 1; i < flen && fill < pdu_len; i++) begin
                                pdu_buf[fill] = it.pay[i];
                                fill++;
                            end
                            if (fill >= pdu_len) begin
                                drop_transfer();
                                deliver_pdu(pdu_len);
                            end
                        end
                    end
                end
                itp_reasm_pkg::FT_FLOW: ;
                default: push_abort(itp_reasm_pkg::RSN_UNEXPECTED);
            endcase
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(t_reply got);
            t_reply want;
            if (awaited_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d data %h",
                                          got.kind, got.data));
                return;
            end
            want = awaited_replies.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.data !== want.data)
                report_mismatch($sformatf("chunk_data %h, want %h", got.data, want.data));
            if (got.nbytes !== want.nbytes)
                report_mismatch($sformatf("chunk_bytes %0d, want %0d",
                                          got.nbytes, want.nbytes));
            if (got.fin !== want.fin)
                report_mismatch($sformatf("last %0d, want %0d", got.fin, want.fin));
            if (got.fs !== want.fs)
                report_mismatch($sformatf("flow_status %0d, want %0d", got.fs, want.fs));
            if (got.reason !== want.reason)
                report_mismatch($sformatf("abort_reason %0d, want %0d",
                                          got.reason, want.reason));
        endtask

        task check_drained();
            if (awaited_replies.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          awaited_replies.size()));
        endtask
    endclass

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [itp_reasm_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic                                  s_axis_tuser = 1'b0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [itp_reasm_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
    logic [1:0]                            m_axis_tuser;
    logic                                  m_axis_tlast;
    logic                                  i_cfg_wr_en = 1'b0;
    logic [15:0]                           i_cfg_wr_data = '0;

    t_reasm_scoreboard sb;
    bit                gaps_on = 1'b1;
    int                items_sent = 0;
    int                stuck_cycles = 0;

    iso_tp_segment_reassembler_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge i_clk) begin
        t_reply    got;
        t_can_item seen;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind   = m_axis_tuser;
                got.data   = m_axis_tdata[63:0];
                got.nbytes = m_axis_tdata[67:64];
                got.fin    = m_axis_tlast;
                got.fs     = m_axis_tdata[68];
                got.reason = m_axis_tdata[70:69];
                sb.check_result(got);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.op   = s_axis_tuser;
                seen.flen = s_axis_tdata[3:0];
                seen.pay  = s_axis_tdata[67:4];
                sb.reassemble(seen);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("iso_tp_segment_reassembler_top_tb failed");
            $finish;
        end
    end

    function automatic t_can_item frame_of(logic [7:0] pci, logic [3:0] flen);
        t_can_item it;
        it.op     = itp_reasm_pkg::OP_FRAME;
        it.flen   = flen;
        it.pay    = {$urandom, $urandom};
        it.pay[0] = pci;
        return it;
    endfunction

    function automatic t_can_item tick_of();
        t_can_item it;
        it.op   = itp_reasm_pkg::OP_TICK;
        it.flen = 4'($urandom_range(0, 15));
        it.pay  = {$urandom, $urandom};
        return it;
    endfunction

    function automatic t_can_item sf_of(int len, logic [3:0] flen);
        return frame_of({itp_reasm_pkg::FT_SINGLE, 4'(len)}, flen);
    endfunction

    function automatic t_can_item ff_of(int total);
        t_can_item it;
        it = frame_of({itp_reasm_pkg::FT_FIRST, 4'(total >> 8)}, 4'd8);
        it.pay[1] = 8'(total);
        return it;
    endfunction

    function automatic t_can_item cf_of(logic [3:0] sn, logic [3:0] flen);
        return frame_of({itp_reasm_pkg::FT_CONSEC, sn}, flen);
    endfunction

    task automatic send(t_can_item it, bit counted);
        while (gaps_on && $urandom_range(0, 99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.pay, it.flen};
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (counted) items_sent++;
    endtask

    // drain every expected result, then let frames that produce none finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_timeout(v);
    endtask

    task automatic send_transfer(int total, int tmo);
        int          have;
        int          nt;
        int          fl;
        logic [3:0]  sn;
        t_can_item   it;
        send(ff_of(total), 1'b1);
        if (total > itp_reasm_pkg::BUF_BYTES || total <= itp_reasm_pkg::SF_MAX) return;
        have = itp_reasm_pkg::FF_BYTES;
        sn   = 4'd1;
        while (have < total) begin
            nt = $urandom_range(0, (tmo > 4) ? 3 : tmo - 1);
            repeat (nt) send(tick_of(), 1'b1);
            if ($urandom_range(0, 99) < 6) begin
                case ($urandom_range(0, 5))
                    0: begin
                        send(cf_of(sn + 4'd1 + 4'($urandom_range(0, 14)), 4'd8), 1'b1);
                        return;
                    end
                    1: begin
                        if (tmo <= 8) begin
                            repeat (tmo - nt) send(tick_of(), 1'b1);
                        end else begin
                            send(frame_of({4'($urandom_range(4, 15)), 4'($urandom)}, 4'd8),
                                 1'b1);
                        end
                        return;
                    end
                    2: begin
                        send(frame_of({4'($urandom_range(4, 15)), 4'($urandom)},
                                      4'($urandom_range(1, 8))), 1'b1);
                        return;
                    end
                    3: begin
                        send(sf_of($urandom_range(1, 7), 4'd8), 1'b1);
                        return;
                    end
                    4: send(frame_of({itp_reasm_pkg::FT_FLOW, 4'($urandom)},
                                     4'($urandom_range(1, 8))), 1'b0);
                    default: begin
                        it = frame_of(8'($urandom), 4'd0);
                        send(it, 1'b1);
                        return;
                    end
                endcase
            end
            fl = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 8;
            send(cf_of(sn, 4'(fl)), 1'b1);
            have += fl - 1;
            sn++;
        end
    endtask

    task automatic random_phase(int count, int tmo, bit start_full);
        int        target;
        int        r;
        int        len;
        t_can_item it;
        target = items_sent + count;
        if (start_full) send_transfer(itp_reasm_pkg::BUF_BYTES, tmo);
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                r = $urandom_range(0, 99);
                if (r < 70)      send_transfer($urandom_range(8, 40), tmo);
                else if (r < 90) send_transfer($urandom_range(41, 255), tmo);
                else if (r < 95) send_transfer(itp_reasm_pkg::BUF_BYTES, tmo);
                else             send_transfer($urandom_range(itp_reasm_pkg::BUF_BYTES + 1,
                                                              4095), tmo);
            end else if (r < 75) begin
                len = $urandom_range(1, 7);
                send(sf_of(len, 4'($urandom_range(len + 1, 8))), 1'b1);
            end else if (r < 90) begin
                it      = frame_of(8'($urandom), 4'($urandom_range(0, 8)));
                it.op   = 1'($urandom);
                send(it, 1'b1);
            end else begin
                repeat ($urandom_range(1, 3)) send(tick_of(), 1'b0);
                send(frame_of({itp_reasm_pkg::FT_FLOW, 4'($urandom)},
                              4'($urandom_range(1, 8))), 1'b0);
            end
        end
        send(sf_of(3, 4'd8), 1'b1);
        settle();
    endtask

    initial begin
        t_can_item it;
        sb = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(sf_of(1, 4'd2), 1'b1);
        it = sf_of(7, 4'd8);
        it.pay[7:1] = '1;
        send(it, 1'b1);
        it = sf_of(7, 4'd15);
        it.pay[7:1] = '0;
        send(it, 1'b1);
        send(sf_of(0, 4'd8), 1'b1);
        send(sf_of(8, 4'd8), 1'b1);
        send(sf_of(15, 4'd8), 1'b1);
        send(sf_of(5, 4'd3), 1'b1);
        send(frame_of(8'h01, 4'd0), 1'b1);
        send(frame_of(8'h4A, 4'd8), 1'b1);
        send(frame_of(8'hFF, 4'd8), 1'b1);
        send(frame_of({itp_reasm_pkg::FT_FLOW, 4'h0}, 4'd3), 1'b1);
        send(cf_of(4'd1, 4'd8), 1'b1);
        send(tick_of(), 1'b1);
        it = ff_of(100);
        it.flen = 4'd7;
        send(it, 1'b1);
        send(ff_of(7), 1'b1);
        send(ff_of(itp_reasm_pkg::BUF_BYTES + 1), 1'b1);
        send(ff_of(4095), 1'b1);
        send(ff_of(8), 1'b1);
        send(cf_of(4'd1, 4'd8), 1'b1);
        send(ff_of(20), 1'b1);
        send(sf_of(3, 4'd4), 1'b1);
        send(cf_of(4'd1, 4'd8), 1'b1);
        send(ff_of(20), 1'b1);
        it = ff_of(10);
        it.flen = 4'd12;
        send(it, 1'b1);
        send(cf_of(4'd1, 4'd8), 1'b1);
        send(ff_of(20), 1'b1);
        send(cf_of(4'd2, 4'd8), 1'b1);
        settle();

        write_timeout(16'd0);
        send(tick_of(), 1'b1);
        send(ff_of(30), 1'b1);
        send(tick_of(), 1'b1);
        settle();

        write_timeout(16'd1);
        send(ff_of(30), 1'b1);
        send(cf_of(4'd1, 4'd8), 1'b1);
        send(tick_of(), 1'b1);
        settle();

        write_timeout(16'd3);
        send(ff_of(30), 1'b1);
        repeat (2) send(tick_of(), 1'b1);
        send(cf_of(4'd1, 4'd8), 1'b1);
        repeat (3) send(tick_of(), 1'b1);
        settle();

        write_timeout(16'd5);
        random_phase(50, 5, 1'b1);

        gaps_on = 1'b0;
        write_timeout(16'hFFFF);
        random_phase(50, 65535, 1'b0);
        gaps_on = 1'b1;

        begin
            int tmo;
            tmo = $urandom_range(2, 12);
            write_timeout(16'(tmo));
            random_phase(50, tmo, 1'b0);
        end

        write_timeout(16'd1);
        random_phase(50, 1, 1'b1);

        repeat (64) @(posedge i_clk);
        sb.check_drained();
        if (sb.mismatches == 0) begin
            $display("iso_tp_segment_reassembler_top_tb passed");
        end else begin
            $display("iso_tp_segment_reassembler_top_tb failed");
        end
        $finish;
    end

endmodule
